[src/rwpd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and a helper function for the RIFF/WAVE parser and downmix.
// Used by the datapath, the controller and the top level.
package rwpd_pkg;

   localparam int MAX_CHANNELS_DEF = 8;
   localparam int SUM_W            = 40;

   // result kinds
   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_DONE   = 2'd1;
   localparam logic [1:0] KIND_FAIL   = 2'd2;

   // chunk and header tags, little-endian as gathered
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [15:0] FMT_PCM   = 16'd1;
   localparam logic [15:0] FMT_FLOAT = 16'd3;
   localparam logic [15:0] BITS_16   = 16'd16;
   localparam logic [15:0] BITS_32   = 16'd32;
   localparam logic [31:0] FMT_MIN_SIZE = 32'd16;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] mono_sample;
      logic [31:0]        rate_hz;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic commit;
      logic div_start;
      logic set_len;
      logic load_smp;
      logic load_tail;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic need_size;
      logic frame_done;
      logic div_done;
      logic tail_any;
      logic end_seen;
   } status_type;

   // IEEE single to Q1.31, truncating, saturating; NaN and subnormals give zero
   function automatic logic signed [31:0] float_to_q31(input logic [31:0] f);
      logic [7:0]  e;
      logic [23:0] m;
      logic [31:0] mag;
      logic [7:0]  rs;
      e   = f[30:23];
      m   = {1'b1, f[22:0]};
      mag = '0;
      rs  = 8'd119 - e;
      if (e == 8'hFF && f[22:0] != 23'd0) begin
         return '0;
      end
      if (e == 8'd0) begin
         return '0;
      end
      if (e >= 8'd127) begin
         return f[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      if (e >= 8'd119) begin
         mag = {8'd0, m} << (e - 8'd119);
      end else if (rs >= 8'd24) begin
         mag = '0;
      end else begin
         mag = {8'd0, m >> rs[4:0]};
      end
      return f[31] ? -$signed(mag) : $signed(mag);
   endfunction

endpackage

[src/rwpd_div.sv]
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Stand-alone; used by the datapath for frame size and channel average.
module rwpd_div #(
   parameter int NW = 40,
   parameter int DW = 9
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quo,
   output logic [DW-1:0] rem
);
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;

   // one restoring step per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[NW-1]};
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DW'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;
endmodule

[src/rwpd_dp.sv]
`timescale 1ns / 1ps
// Parser datapath: tag and field gathering, fmt fields, frame sum, result register.
// Depends on rwpd_pkg and rwpd_div; driven by commands from rwpd_ctrl.
module rwpd_dp #(
   parameter int MAX_CHANNELS = rwpd_pkg::MAX_CHANNELS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rwpd_pkg::cmd_type    cmd,
   output rwpd_pkg::status_type st,
   input  rwpd_pkg::req_type    req_data,
   output rwpd_pkg::rsp_type    rsp_data
);
   localparam int ChW = $clog2(MAX_CHANNELS + 1);
   localparam int FbW = $clog2(MAX_CHANNELS * 4 + 1);
   localparam int SW  = rwpd_pkg::SUM_W;

   typedef enum logic [2:0] {
      PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID, PH_CSIZE, PH_FMT, PH_SKIP, PH_DATA
   } phase_type;

   typedef enum logic [1:0] {CK_OTHER, CK_FMT, CK_DATA} chunk_type;

   phase_type        phase_ff, phase_in;
   chunk_type        ckind_ff, ckind_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [31:0]      gather_ff, gather_in;
   logic [32:0]      left_ff, left_in;
   logic [15:0]      code_ff, code_in;
   logic [15:0]      chans_ff, chans_in;
   logic [31:0]      rate_ff, rate_in;
   logic [15:0]      bits_ff, bits_in;
   logic             seen_ff, seen_in;
   logic [ChW-1:0]   chan_ff, chan_in;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic             closed_ff, closed_in;
   logic             pfin_ff, pfin_in;
   logic             pfail_ff, pfail_in;
   logic             neg_ff, neg_in;
   logic [7:0]       byte_ff, byte_in;
   logic             end_ff, end_in;
   rwpd_pkg::rsp_type rsp_ff, rsp_in;

   logic [31:0]      g;
   logic             ss2;
   logic signed [31:0] conv;
   logic signed [SW-1:0] sum_add;
   logic [FbW-1:0]   fb;
   logic [ChW-1:0]   chan_add;
   logic [32:0]      left_dec;
   logic [32:0]      left_fit;
   logic [31:0]      qlo;
   logic             need_size, frame_done;
   logic [SW-1:0]    div_num;
   logic [FbW-1:0]   div_den;
   logic             div_done;
   logic [SW-1:0]    div_quo;
   logic [FbW-1:0]   div_rem;

   // byte handling, frame completion and result loading
   always_comb begin
      phase_in  = phase_ff;
      ckind_in  = ckind_ff;
      cnt_in    = cnt_ff;
      gather_in = gather_ff;
      left_in   = left_ff;
      code_in   = code_ff;
      chans_in  = chans_ff;
      rate_in   = rate_ff;
      bits_in   = bits_ff;
      seen_in   = seen_ff;
      chan_in   = chan_ff;
      sum_in    = sum_ff;
      closed_in = closed_ff;
      pfin_in   = pfin_ff;
      pfail_in  = pfail_ff;
      neg_in    = neg_ff;
      byte_in   = byte_ff;
      end_in    = end_ff;
      rsp_in    = rsp_ff;
      need_size = 1'b0;
      frame_done = 1'b0;

      g   = gather_ff | ({24'd0, byte_ff} << {cnt_ff[1:0], 3'b000});
      ss2 = (code_ff == rwpd_pkg::FMT_PCM) && (bits_ff == rwpd_pkg::BITS_16);
      if (code_ff == rwpd_pkg::FMT_FLOAT) begin
         conv = rwpd_pkg::float_to_q31(g);
      end else if (bits_ff == rwpd_pkg::BITS_16) begin
         conv = $signed({g[15:0], 16'd0});
      end else begin
         conv = $signed(g);
      end
      sum_add  = sum_ff + SW'(conv);
      fb       = ss2 ? (FbW'(chans_ff[ChW-1:0]) << 1) : (FbW'(chans_ff[ChW-1:0]) << 2);
      chan_add = chan_ff + 1'b1;
      left_dec = left_ff - 33'd1;
      left_fit = left_ff - 33'(div_rem);
      qlo      = div_quo[31:0];
      div_num  = need_size ? {{(SW-32){1'b0}}, g} : '0;
      div_den  = fb;

      // latch the incoming transaction
      if (cmd.capture) begin
         byte_in = req_data.file_byte;
         end_in  = req_data.end_of_input;
      end

      // advance the parse state by one byte
      if (cmd.commit && !closed_ff) begin
         case (phase_ff)
            PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID, PH_CSIZE: begin
               cnt_in    = cnt_ff + 1'b1;
               gather_in = g;
               if (cnt_ff[1:0] == 2'd3) begin
                  cnt_in    = '0;
                  gather_in = '0;
                  case (phase_ff)
                     PH_RIFF: begin
                        if (g != rwpd_pkg::TAG_RIFF) begin
                           pfail_in = 1'b1;
                           closed_in = 1'b1;
                        end else begin
                           phase_in = PH_RSIZE;
                        end
                     end
                     PH_RSIZE: phase_in = PH_WAVE;
                     PH_WAVE: begin
                        if (g != rwpd_pkg::TAG_WAVE) begin
                           pfail_in = 1'b1;
                           closed_in = 1'b1;
                        end else begin
                           phase_in = PH_CID;
                        end
                     end
                     PH_CID: begin
                        if (g == rwpd_pkg::TAG_FMT) begin
                           ckind_in = CK_FMT;
                        end else if (g == rwpd_pkg::TAG_DATA) begin
                           ckind_in = CK_DATA;
                        end else begin
                           ckind_in = CK_OTHER;
                        end
                        phase_in = PH_CSIZE;
                     end
                     default: begin
                        case (ckind_ff)
                           CK_FMT: begin
                              if (g < rwpd_pkg::FMT_MIN_SIZE) begin
                                 pfail_in = 1'b1;
                                 closed_in = 1'b1;
                              end else begin
                                 left_in  = {1'b0, g};
                                 phase_in = PH_FMT;
                              end
                           end
                           CK_DATA: begin
                              if (!seen_ff || chans_ff == 16'd0 ||
                                  chans_ff > 16'(MAX_CHANNELS) ||
                                  (code_ff == rwpd_pkg::FMT_PCM &&
                                   bits_ff != rwpd_pkg::BITS_16 &&
                                   bits_ff != rwpd_pkg::BITS_32) ||
                                  (code_ff != rwpd_pkg::FMT_PCM &&
                                   code_ff != rwpd_pkg::FMT_FLOAT)) begin
                                 pfail_in = 1'b1;
                                 closed_in = 1'b1;
                              end else begin
                                 left_in   = {1'b0, g};
                                 need_size = 1'b1;
                              end
                           end
                           default: begin
                              left_in  = {1'b0, g} + 33'(g[0]);
                              phase_in = (g == 32'd0) ? PH_CID : PH_SKIP;
                           end
                        endcase
                     end
                  endcase
               end
            end
            PH_FMT: begin
               cnt_in = cnt_ff + 1'b1;
               case (cnt_ff)
                  5'd0: code_in = {8'd0, byte_ff};
                  5'd1: code_in = {byte_ff, code_ff[7:0]};
                  5'd2: chans_in = {8'd0, byte_ff};
                  5'd3: chans_in = {byte_ff, chans_ff[7:0]};
                  5'd4: rate_in = {24'd0, byte_ff};
                  5'd5, 5'd6, 5'd7:
                     rate_in = rate_ff | ({24'd0, byte_ff} << {cnt_ff[1:0], 3'b000});
                  5'd14: bits_in = {8'd0, byte_ff};
                  5'd15: bits_in = {byte_ff, bits_ff[7:0]};
                  default: ;
               endcase
               if (cnt_ff == 5'd15) begin
                  seen_in  = 1'b1;
                  cnt_in   = '0;
                  left_in  = left_ff - 33'd16 + 33'(left_ff[0]);
                  phase_in = (left_ff - 33'd16 + 33'(left_ff[0]) == 33'd0) ? PH_CID : PH_SKIP;
               end
            end
            PH_SKIP: begin
               left_in = left_dec;
               if (left_dec == 33'd0) begin
                  phase_in = PH_CID;
               end
            end
            default: begin
               cnt_in    = cnt_ff + 1'b1;
               gather_in = g;
               left_in   = left_dec;
               if ((cnt_ff[2:0] + 3'd1) >= (ss2 ? 3'd2 : 3'd4)) begin
                  gather_in = '0;
                  cnt_in    = '0;
                  sum_in    = sum_add;
                  chan_in   = chan_add;
                  if (16'(chan_add) >= chans_ff) begin
                     frame_done = 1'b1;
                     neg_in     = sum_add[SW-1];
                     sum_in     = '0;
                     chan_in    = '0;
                  end
               end
               if (left_dec == 33'd0) begin
                  pfin_in   = 1'b1;
                  closed_in = 1'b1;
               end
            end
         endcase
      end

      if (need_size) begin
         div_num = {{(SW-32){1'b0}}, g};
         div_den = fb;
      end else begin
         div_num = sum_add[SW-1] ? SW'(-sum_add) : SW'(sum_add);
         div_den = FbW'(chans_ff[ChW-1:0]);
      end

      // trim the data chunk to whole frames
      if (cmd.set_len) begin
         left_in = left_fit;
         if (left_fit == 33'd0) begin
            pfin_in   = 1'b1;
            closed_in = 1'b1;
         end else begin
            phase_in  = PH_DATA;
            cnt_in    = '0;
            gather_in = '0;
            chan_in   = '0;
            sum_in    = '0;
         end
      end

      if (cmd.load_smp) begin
         rsp_in.kind        = rwpd_pkg::KIND_SAMPLE;
         rsp_in.mono_sample = neg_ff ? -$signed(qlo) : $signed(qlo);
         rsp_in.rate_hz     = rate_ff;
         rsp_in.last        = 1'b0;
      end

      // closing result: finish, or failure on a header error or an early end
      if (cmd.load_tail) begin
         rsp_in.kind        = pfin_ff ? rwpd_pkg::KIND_DONE : rwpd_pkg::KIND_FAIL;
         rsp_in.mono_sample = '0;
         rsp_in.rate_hz     = pfin_ff ? rate_ff : 32'd0;
         rsp_in.last        = 1'b1;
         pfin_in   = 1'b0;
         pfail_in  = 1'b0;
         closed_in = 1'b1;
      end

      // end of file: drop all parse state
      if (cmd.clear) begin
         phase_in  = PH_RIFF;
         ckind_in  = CK_OTHER;
         cnt_in    = '0;
         gather_in = '0;
         left_in   = '0;
         code_in   = '0;
         chans_in  = '0;
         rate_in   = '0;
         bits_in   = '0;
         seen_in   = 1'b0;
         chan_in   = '0;
         sum_in    = '0;
         closed_in = 1'b0;
         pfin_in   = 1'b0;
         pfail_in  = 1'b0;
      end
   end

   rwpd_div #(.NW(SW), .DW(FbW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_RIFF;
         ckind_ff  <= CK_OTHER;
         cnt_ff    <= '0;
         gather_ff <= '0;
         left_ff   <= '0;
         code_ff   <= '0;
         chans_ff  <= '0;
         rate_ff   <= '0;
         bits_ff   <= '0;
         seen_ff   <= 1'b0;
         chan_ff   <= '0;
         sum_ff    <= '0;
         closed_ff <= 1'b0;
         pfin_ff   <= 1'b0;
         pfail_ff  <= 1'b0;
         end_ff    <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         ckind_ff  <= ckind_in;
         cnt_ff    <= cnt_in;
         gather_ff <= gather_in;
         left_ff   <= left_in;
         code_ff   <= code_in;
         chans_ff  <= chans_in;
         rate_ff   <= rate_in;
         bits_ff   <= bits_in;
         seen_ff   <= seen_in;
         chan_ff   <= chan_in;
         sum_ff    <= sum_in;
         closed_ff <= closed_in;
         pfin_ff   <= pfin_in;
         pfail_ff  <= pfail_in;
         end_ff    <= end_in;
      end
      neg_ff  <= neg_in;
      byte_ff <= byte_in;
      rsp_ff  <= rsp_in;
   end

   assign st.need_size  = need_size;
   assign st.frame_done = frame_done;
   assign st.div_done   = div_done;
   assign st.tail_any   = pfin_ff | pfail_ff | (end_ff & ~closed_ff);
   assign st.end_seen   = end_ff;
   assign rsp_data      = rsp_ff;
endmodule

[src/rwpd_ctrl.sv]
`timescale 1ns / 1ps
// Controller: sequences byte capture, parse, divides and result hand-off.
// Depends on rwpd_pkg; commands the datapath rwpd_dp.
module rwpd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rwpd_pkg::status_type st,
   output rwpd_pkg::cmd_type    cmd
);
   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_DSIZE, S_DAVG, S_SMP, S_TAIL, S_TOUT, S_END
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.commit = 1'b1;
            if (st.need_size) begin
               cmd.div_start = 1'b1;
               state_in      = S_DSIZE;
            end else if (st.frame_done) begin
               cmd.div_start = 1'b1;
               state_in      = S_DAVG;
            end else begin
               state_in = S_TAIL;
            end
         end
         S_DSIZE: begin
            if (st.div_done) begin
               cmd.set_len = 1'b1;
               state_in    = S_TAIL;
            end
         end
         S_DAVG: begin
            if (st.div_done) begin
               cmd.load_smp = 1'b1;
               state_in     = S_SMP;
            end
         end
         S_SMP: begin
            if (!rsp_stall) begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            if (st.tail_any) begin
               cmd.load_tail = 1'b1;
               state_in      = S_TOUT;
            end else begin
               state_in = S_END;
            end
         end
         S_TOUT: begin
            if (!rsp_stall) begin
               state_in = S_END;
            end
         end
         default: begin
            cmd.clear = st.end_seen;
            state_in  = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_SMP) || (state_ff == S_TOUT);

   // one transaction in flight: no result while a byte may be taken
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("result offered while input open");

   // a divide never starts for both frame length and average
   a_one_div: assert property (@(posedge clock) disable iff (reset)
      !(state_ff == S_EXEC && st.need_size && st.frame_done))
      else $error("two divides requested at once");

   // divider result does not appear the cycle after start
   a_div_lat: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !st.div_done)
      else $error("divider finished too early");
endmodule

[src/riff_wave_parser_downmix.sv]
`timescale 1ns / 1ps
// RIFF/WAVE parser with mono downmix: top level joining controller and datapath.
// Depends on rwpd_pkg, rwpd_ctrl, rwpd_dp and rwpd_div.
//
// The block takes one file byte per transaction and handles one byte at a time.
// A byte that produces no result passes through the capture, parse, tail and end
// states before the next byte can be accepted, and a closing result (finish or
// failure) adds a hand-off state. A byte that completes a frame runs the
// channel-average divide on a 40-step restoring divider and then hands off the
// sample. The data chunk header runs the same divide to trim the chunk to whole
// frames. Every hand-off stretches for as long as the downstream side stalls,
// and the input stays stalled meanwhile. A file's end byte returns all parse
// state to its reset values.
module riff_wave_parser_downmix #(
   parameter int MAX_CHANNELS = rwpd_pkg::MAX_CHANNELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rwpd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rwpd_pkg::rsp_type rsp_data
);
   rwpd_pkg::cmd_type    cmd;
   rwpd_pkg::status_type st;

   rwpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .st        (st),
      .cmd       (cmd)
   );

   rwpd_dp #(.MAX_CHANNELS(MAX_CHANNELS)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .st       (st),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );
endmodule
